/* hdl/assert_macros.svh */
// -----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the filter engine RTL.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PFBE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PFBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define PFBE_ASSERT(lbl, clk, rst_n, prop, msg)
`define PFBE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/pfbe_pkg.sv */
// -----------------------------------------------------------------------------
// pfbe_pkg
// Types, opcode fields and constants of the packet filter bytecode engine.
// -----------------------------------------------------------------------------
package pfbe_pkg;

	localparam int PROGRAM_DEPTH_DEF = 256;
	localparam int PACKET_DEPTH_DEF  = 2048;
	localparam int SCRATCH_DEPTH     = 16;

	// Item operations.
	localparam logic [1:0] OP_WR_INSN = 2'd0;
	localparam logic [1:0] OP_WR_PKT  = 2'd1;
	localparam logic [1:0] OP_RUN     = 2'd2;

	// End causes.
	localparam logic [1:0] CAUSE_RET   = 2'd0;
	localparam logic [1:0] CAUSE_DIV0  = 2'd1;
	localparam logic [1:0] CAUSE_END   = 2'd2;
	localparam logic [1:0] CAUSE_EMPTY = 2'd3;

	// Instruction classes (code bits 2..0).
	localparam logic [2:0] CLS_LD   = 3'd0;
	localparam logic [2:0] CLS_LDX  = 3'd1;
	localparam logic [2:0] CLS_ST   = 3'd2;
	localparam logic [2:0] CLS_STX  = 3'd3;
	localparam logic [2:0] CLS_ALU  = 3'd4;
	localparam logic [2:0] CLS_JMP  = 3'd5;
	localparam logic [2:0] CLS_RET  = 3'd6;
	localparam logic [2:0] CLS_MISC = 3'd7;

	// Addressing modes (code bits 7..5).
	localparam logic [2:0] MODE_IMM = 3'd0;
	localparam logic [2:0] MODE_ABS = 3'd1;
	localparam logic [2:0] MODE_IND = 3'd2;
	localparam logic [2:0] MODE_MEM = 3'd3;
	localparam logic [2:0] MODE_LEN = 3'd4;
	localparam logic [2:0] MODE_MSH = 3'd5;

	// Load sizes (code bits 4..3).
	localparam logic [1:0] SIZE_W = 2'd0;
	localparam logic [1:0] SIZE_H = 2'd1;
	localparam logic [1:0] SIZE_B = 2'd2;

	// ALU operations (code bits 7..4).
	localparam logic [3:0] ALU_ADD = 4'h0;
	localparam logic [3:0] ALU_SUB = 4'h1;
	localparam logic [3:0] ALU_MUL = 4'h2;
	localparam logic [3:0] ALU_DIV = 4'h3;
	localparam logic [3:0] ALU_OR  = 4'h4;
	localparam logic [3:0] ALU_AND = 4'h5;
	localparam logic [3:0] ALU_LSH = 4'h6;
	localparam logic [3:0] ALU_RSH = 4'h7;
	localparam logic [3:0] ALU_NEG = 4'h8;
	localparam logic [3:0] ALU_MOD = 4'h9;
	localparam logic [3:0] ALU_XOR = 4'ha;

	// Jump operations (code bits 7..4).
	localparam logic [3:0] JMP_JA   = 4'h0;
	localparam logic [3:0] JMP_JEQ  = 4'h1;
	localparam logic [3:0] JMP_JGT  = 4'h2;
	localparam logic [3:0] JMP_JGE  = 4'h3;
	localparam logic [3:0] JMP_JSET = 4'h4;

	// Misc operations (code bits 7..3).
	localparam logic [4:0] MISC_TAX = 5'h00;
	localparam logic [4:0] MISC_TXA = 5'h10;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC,
		ST_PKT,
		ST_PKTW,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* hdl/pfbe_if.sv */
// -----------------------------------------------------------------------------
// pfbe_if
// Valid/ready channels of the filter engine: command, response, configuration.
// -----------------------------------------------------------------------------
interface pfbe_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [10:0] slot;
	logic [15:0] insn_code;
	logic [7:0]  jump_true;
	logic [7:0]  jump_false;
	logic [31:0] immediate;
	logic [7:0]  packet_byte;
	logic [11:0] packet_length;

	modport source (output valid, operation, slot, insn_code, jump_true, jump_false,
		immediate, packet_byte, packet_length, input ready);
	modport sink (input valid, operation, slot, insn_code, jump_true, jump_false,
		immediate, packet_byte, packet_length, output ready);
endinterface

interface pfbe_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] verdict;
	logic [1:0]  end_cause;

	modport source (output valid, verdict, end_cause, input ready);
	modport sink (input valid, verdict, end_cause, output ready);
endinterface

interface pfbe_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

/* hdl/packet_filter_bytecode_engine.sv */
// -----------------------------------------------------------------------------
// packet_filter_bytecode_engine
// Classic packet filter machine executing a stored program over a stored packet.
// -----------------------------------------------------------------------------
// Usage: cmd carries one item per transaction. Instruction and packet byte writes
// give no response. A run item executes the program from instruction 0 and gives
// one rsp transaction with verdict and end_cause. cfg writes program_length and
// is always ready; write it only while idle. cmd.ready is high only while the
// sequencer idles. Each executed instruction passes a program store read and an
// execute step; a packet load adds a read and a capture step per byte through the
// single packet store read port, and a divide or modulo runs in the shared
// one-bit-per-cycle divider. A run ends in the done state, which waits for a free
// response register, before the engine is ready again. An empty program goes from
// the run transaction straight to the done state. Reset clears the registers,
// apart from the two store read registers, and program_length; both stores are
// undefined until written and need no clearing. The response is held in an output
// register: while rsp stalls, writes are still taken, and a further run holds
// its result in the sequencer until the pending transaction completes.
module packet_filter_bytecode_engine
	import pfbe_pkg::*;
#(
	parameter int PROGRAM_DEPTH = PROGRAM_DEPTH_DEF,
	parameter int PACKET_DEPTH  = PACKET_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	pfbe_cmd_if.sink   cmd,
	pfbe_rsp_if.source rsp,
	pfbe_cfg_if.sink   cfg
);
`include "assert_macros.svh"

	localparam int PAW = $clog2(PROGRAM_DEPTH);
	localparam int PKW = $clog2(PACKET_DEPTH);
	localparam int LW  = ($clog2(PACKET_DEPTH + 1) > 12) ? $clog2(PACKET_DEPTH + 1) : 12;

	state_t state_q, state_d;

	logic [63:0] prog_mem [PROGRAM_DEPTH];
	logic [7:0]  pkt_mem [PACKET_DEPTH];
	logic [63:0] ir_q;
	logic [7:0]  pkt_rd_q;

	logic [8:0]    len_q;
	logic [LW-1:0] plen_q;
	logic [PAW-1:0] pc_q;
	logic [31:0] acc_q, x_q;
	logic [31:0] scratch_q [SCRATCH_DEPTH];
	logic [PKW-1:0] pa_q;
	logic [2:0]  bcnt_q;
	logic [23:0] ld_q;
	logic        ld_x_q;
	logic [31:0] rem_q, quo_q, dvs_q;
	logic [4:0]  dcnt_q;
	logic        div_mod_q;
	logic [31:0] res_verdict_q;
	logic [1:0]  res_cause_q;
	logic        rsp_valid_q;
	logic [31:0] rsp_verdict_q;
	logic [1:0]  rsp_cause_q;

	logic cmd_fire, prog_rd, pkt_rd, rsp_free;

	// Instruction fields.
	logic [15:0] code;
	logic [31:0] k, src, skip;
	logic [2:0]  cls, mode;
	logic [3:0]  op;
	logic [1:0]  size;
	assign code = ir_q[63:48];
	assign k    = ir_q[31:0];
	assign cls  = code[2:0];
	assign mode = code[7:5];
	assign op   = code[7:4];
	assign size = code[4:3];
	assign src  = code[3] ? x_q : k;

	logic [32:0] n_ext, pc_sum, offset;
	logic [33:0] ld_end;
	logic [2:0]  nbytes;
	logic        size_ok, ld_pkt, pkt_oob, is_jmp, cond, pc_done, k_in_scr;
	logic        div_op, div_zero, last_byte, div_last;
	logic [32:0] dstep;
	logic        dge;
	logic [31:0] dr_next, dq_next;

	assign n_ext = (33'(len_q) > 33'(PROGRAM_DEPTH)) ? 33'(PROGRAM_DEPTH) : 33'(len_q);
	assign k_in_scr = (k[31:4] == 28'd0);

	always_comb begin
		case (size)
			SIZE_W:  nbytes = 3'd4;
			SIZE_H:  nbytes = 3'd2;
			SIZE_B:  nbytes = 3'd1;
			default: nbytes = 3'd0;
		endcase
		if (cls == CLS_LDX) begin
			nbytes = 3'd1;
		end
	end

	assign size_ok = (size != 2'd3);
	assign ld_pkt = ((cls == CLS_LD) && ((mode == MODE_ABS) || (mode == MODE_IND)) && size_ok)
		|| ((cls == CLS_LDX) && (mode == MODE_MSH));
	assign offset = ((cls == CLS_LD) && (mode == MODE_IND)) ? ({1'b0, x_q} + {1'b0, k})
		: {1'b0, k};
	assign ld_end  = {1'b0, offset} + 34'(nbytes);
	assign pkt_oob = ld_end > 34'(plen_q);

	always_comb begin
		case (op)
			JMP_JEQ:  cond = (acc_q == src);
			JMP_JGT:  cond = (acc_q > src);
			JMP_JGE:  cond = (acc_q >= src);
			JMP_JSET: cond = ((acc_q & src) != 32'd0);
			default:  cond = 1'b0;
		endcase
	end

	// Unknown jump ops fall through to the next instruction.
	assign is_jmp = (cls == CLS_JMP) && (op inside {JMP_JA, JMP_JEQ, JMP_JGT, JMP_JGE, JMP_JSET});
	always_comb begin
		skip = 32'd0;
		if (state_q == ST_EXEC && is_jmp) begin
			if (op == JMP_JA) begin
				skip = k;
			end else begin
				skip = cond ? 32'(ir_q[47:40]) : 32'(ir_q[39:32]);
			end
		end
	end
	assign pc_sum  = 33'(pc_q) + 33'(skip) + 33'd1;
	assign pc_done = pc_sum >= n_ext;

	assign div_op   = (cls == CLS_ALU) && ((op == ALU_DIV) || (op == ALU_MOD));
	assign div_zero = div_op && (src == 32'd0);

	assign dstep   = {rem_q, quo_q[31]};
	assign dge     = dstep >= {1'b0, dvs_q};
	assign dr_next = dge ? 32'(dstep - {1'b0, dvs_q}) : dstep[31:0];
	assign dq_next = {quo_q[30:0], dge};
	assign div_last  = (dcnt_q == 5'd31);
	assign last_byte = (bcnt_q == 3'd1);

	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign cmd_fire = cmd.valid && cmd.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_fire && cmd.operation == OP_RUN) begin
					state_d = (n_ext == 33'd0) ? ST_DONE : ST_FETCH;
				end
			end
			ST_FETCH: state_d = ST_EXEC;
			ST_EXEC: begin
				if (cls == CLS_RET || div_zero) begin
					state_d = ST_DONE;
				end else if (ld_pkt && !pkt_oob) begin
					state_d = ST_PKT;
				end else if (div_op) begin
					state_d = ST_DIV;
				end else begin
					state_d = pc_done ? ST_DONE : ST_FETCH;
				end
			end
			ST_PKT: state_d = ST_PKTW;
			ST_PKTW: begin
				if (!last_byte) begin
					state_d = ST_PKT;
				end else begin
					state_d = pc_done ? ST_DONE : ST_FETCH;
				end
			end
			ST_DIV: begin
				if (div_last) begin
					state_d = pc_done ? ST_DONE : ST_FETCH;
				end
			end
			ST_DONE: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		cfg.ready = 1'b1;
		prog_rd   = (state_q == ST_FETCH);
		pkt_rd    = (state_q == ST_PKT);
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.verdict   = rsp_verdict_q;
	assign rsp.end_cause = rsp_cause_q;

	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.operation == OP_WR_INSN && 32'(cmd.slot) < 32'(PROGRAM_DEPTH)) begin
			prog_mem[PAW'(cmd.slot)] <= {cmd.insn_code, cmd.jump_true, cmd.jump_false,
				cmd.immediate};
		end
		if (prog_rd) begin
			ir_q <= prog_mem[pc_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire && cmd.operation == OP_WR_PKT && 32'(cmd.slot) < 32'(PACKET_DEPTH)) begin
			pkt_mem[PKW'(cmd.slot)] <= cmd.packet_byte;
		end
		if (pkt_rd) begin
			pkt_rd_q <= pkt_mem[pa_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			len_q         <= 9'd0;
			plen_q        <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_verdict_q <= 32'd0;
			rsp_cause_q   <= CAUSE_RET;
			res_verdict_q <= 32'd0;
			res_cause_q   <= CAUSE_RET;
			dcnt_q        <= 5'd0;
			pc_q          <= '0;
			acc_q         <= 32'd0;
			x_q           <= 32'd0;
			pa_q          <= '0;
			bcnt_q        <= 3'd0;
			ld_q          <= 24'd0;
			ld_x_q        <= 1'b0;
			rem_q         <= 32'd0;
			quo_q         <= 32'd0;
			dvs_q         <= 32'd0;
			div_mod_q     <= 1'b0;
			for (int i = 0; i < SCRATCH_DEPTH; i++) begin
				scratch_q[i] <= 32'd0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				len_q <= cfg.data;
			end
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q   <= 1'b1;
				rsp_verdict_q <= res_verdict_q;
				rsp_cause_q   <= res_cause_q;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_fire && cmd.operation == OP_RUN) begin
						acc_q <= 32'd0;
						x_q   <= 32'd0;
						pc_q  <= '0;
						for (int i = 0; i < SCRATCH_DEPTH; i++) begin
							scratch_q[i] <= 32'd0;
						end
						plen_q <= (32'(cmd.packet_length) > 32'(PACKET_DEPTH))
							? LW'(PACKET_DEPTH) : LW'(cmd.packet_length);
						res_verdict_q <= 32'd1;
						res_cause_q   <= CAUSE_EMPTY;
					end
				end
				ST_EXEC: begin
					case (cls)
						CLS_LD: begin
							case (mode)
								MODE_IMM: acc_q <= k;
								MODE_ABS, MODE_IND: begin
									if (size_ok && pkt_oob) begin
										acc_q <= 32'd0;
									end
								end
								MODE_MEM: begin
									if (k_in_scr) begin
										acc_q <= scratch_q[k[3:0]];
									end
								end
								MODE_LEN: acc_q <= 32'(plen_q);
								default: ;
							endcase
						end
						CLS_LDX: begin
							case (mode)
								MODE_IMM: x_q <= k;
								MODE_MEM: begin
									if (k_in_scr) begin
										x_q <= scratch_q[k[3:0]];
									end
								end
								MODE_LEN: x_q <= 32'(plen_q);
								MODE_MSH: begin
									if (pkt_oob) begin
										x_q <= 32'd0;
									end
								end
								default: ;
							endcase
						end
						CLS_ST: begin
							if (k_in_scr) begin
								scratch_q[k[3:0]] <= acc_q;
							end
						end
						CLS_STX: begin
							if (k_in_scr) begin
								scratch_q[k[3:0]] <= x_q;
							end
						end
						CLS_ALU: begin
							case (op)
								ALU_ADD: acc_q <= acc_q + src;
								ALU_SUB: acc_q <= acc_q - src;
								ALU_MUL: acc_q <= 32'(acc_q * src);
								ALU_OR:  acc_q <= acc_q | src;
								ALU_AND: acc_q <= acc_q & src;
								ALU_LSH: acc_q <= (src < 32'd32) ? (acc_q << src[4:0]) : 32'd0;
								ALU_RSH: acc_q <= (src < 32'd32) ? (acc_q >> src[4:0]) : 32'd0;
								ALU_NEG: acc_q <= 32'd0 - acc_q;
								ALU_XOR: acc_q <= acc_q ^ src;
								default: ;
							endcase
						end
						CLS_MISC: begin
							if (code[7:3] == MISC_TAX) begin
								x_q <= acc_q;
							end else if (code[7:3] == MISC_TXA) begin
								acc_q <= x_q;
							end
						end
						default: ;
					endcase

					// Start a packet read or a division.
					pa_q      <= PKW'(offset);
					bcnt_q    <= nbytes;
					ld_q      <= 24'd0;
					ld_x_q    <= (cls == CLS_LDX);
					rem_q     <= 32'd0;
					quo_q     <= acc_q;
					dvs_q     <= src;
					div_mod_q <= (op == ALU_MOD);

					if (cls == CLS_RET) begin
						res_verdict_q <= (size == SIZE_B) ? acc_q : k;
						res_cause_q   <= CAUSE_RET;
					end else if (div_zero) begin
						res_verdict_q <= 32'd0;
						res_cause_q   <= CAUSE_DIV0;
					end else if (!(ld_pkt && !pkt_oob) && !div_op) begin
						if (pc_done) begin
							res_verdict_q <= 32'd0;
							res_cause_q   <= CAUSE_END;
						end else begin
							pc_q <= PAW'(pc_sum);
						end
					end
				end
				ST_PKTW: begin
					ld_q   <= {ld_q[15:0], pkt_rd_q};
					pa_q   <= pa_q + PKW'(1);
					bcnt_q <= bcnt_q - 3'd1;
					if (last_byte) begin
						if (ld_x_q) begin
							x_q <= {26'd0, pkt_rd_q[3:0], 2'b00};
						end else begin
							acc_q <= {ld_q, pkt_rd_q};
						end
						if (pc_done) begin
							res_verdict_q <= 32'd0;
							res_cause_q   <= CAUSE_END;
						end else begin
							pc_q <= PAW'(pc_sum);
						end
					end
				end
				ST_DIV: begin
					rem_q  <= dr_next;
					quo_q  <= dq_next;
					dcnt_q <= dcnt_q + 5'd1;
					if (div_last) begin
						acc_q <= div_mod_q ? dr_next : dq_next;
						if (pc_done) begin
							res_verdict_q <= 32'd0;
							res_cause_q   <= CAUSE_END;
						end else begin
							pc_q <= PAW'(pc_sum);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// A response appears only when a finished run hands it over.
	`PFBE_ASSERT_IMP(a_rsp_from_done, clk, arst_n, $rose(rsp_valid_q),
		$past(state_q) == ST_DONE, "response raised outside the done state")
	// The divider counter runs only during a division.
	`PFBE_ASSERT_IMP(a_div_cnt, clk, arst_n, dcnt_q != 5'd0, state_q == ST_DIV,
		"divider count active outside a division")
	// Every fetch stays inside the program.
	`PFBE_ASSERT_IMP(a_fetch_in_range, clk, arst_n, state_q == ST_FETCH,
		33'(pc_q) < n_ext, "fetch beyond the program length")

endmodule

/* test/testbench.sv */
// -----------------------------------------------------------------------------
// testbench
// Self-checking test of the packet filter bytecode engine. The program store
// and the low packet region are filled first, then short directed programs
// cover the special cases, then random programs with random packets run under
// random stalls on the command and response channels. A predictor in this file
// computes each run's verdict and end cause, and every response is checked.
// -----------------------------------------------------------------------------
module testbench;
	import pfbe_pkg::*;

	// Packet bytes below this offset are written before any run; random runs
	// never use a longer packet, so no load touches an unwritten byte.
	localparam int PKT_FILL = 256;

	typedef struct {
		logic [1:0]  operation;
		logic [10:0] slot;
		logic [15:0] insn_code;
		logic [7:0]  jump_true;
		logic [7:0]  jump_false;
		logic [31:0] immediate;
		logic [7:0]  packet_byte;
		logic [11:0] packet_length;
	} filter_item_t;

	typedef struct packed {
		logic [31:0] verdict;
		logic [1:0]  end_cause;
	} verdict_t;

	logic clk;
	logic arst_n;

	pfbe_cmd_if cmd_ch();
	pfbe_rsp_if rsp_ch();
	pfbe_cfg_if cfg_ch();

	packet_filter_bytecode_engine dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch),
		.cfg(cfg_ch)
	);

	// Predictor state.
	logic [63:0] insn_mem [PROGRAM_DEPTH_DEF];
	logic [7:0]  pkt_mem [PACKET_DEPTH_DEF];
	logic [8:0]  prog_len_reg;

	verdict_t verdict_queue[$];
	int errors;
	int item_count;
	int run_count;
	int cause_seen [4];
	bit quiet;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#1000000000;
		$display("packet_filter_bytecode_engine test failed");
		$finish;
	end

	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 0;
		if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pkt_fetch(logic [63:0] off, int nb, logic [31:0] len);
		logic [31:0] v;
		logic [63:0] a;
		v = '0;
		if (off + 64'(nb) > {32'b0, len})
			return '0;
		for (int i = 0; i < nb; i++) begin
			a = off + 64'(i);
			v = {v[23:0], (a < PACKET_DEPTH_DEF) ? pkt_mem[a[10:0]] : 8'h00};
		end
		return v;
	endfunction

	function automatic logic [31:0] sized_fetch(logic [15:0] code, logic [63:0] off,
		logic [31:0] len, logic [31:0] old);
		case (code[4:3])
			SIZE_W: return pkt_fetch(off, 4, len);
			SIZE_H: return pkt_fetch(off, 2, len);
			SIZE_B: return pkt_fetch(off, 1, len);
			default: return old;
		endcase
	endfunction

	function automatic verdict_t predict_run(logic [11:0] plen_in);
		verdict_t res;
		logic [31:0] a, x, k, s, plen, tmp;
		logic [31:0] mem [SCRATCH_DEPTH];
		logic [63:0] w, pc, n;
		logic [15:0] code;
		logic [7:0] jt, jf;
		logic [3:0] op;
		bit cond, jumped;
		plen = (plen_in > PACKET_DEPTH_DEF) ? 32'(PACKET_DEPTH_DEF) : {20'b0, plen_in};
		n = (prog_len_reg > PROGRAM_DEPTH_DEF) ? 64'(PROGRAM_DEPTH_DEF) : {55'b0, prog_len_reg};
		a = '0;
		x = '0;
		foreach (mem[i])
			mem[i] = '0;
		if (n == 0) begin
			res.verdict = 32'd1;
			res.end_cause = CAUSE_EMPTY;
			return res;
		end
		pc = '0;
		while (pc < n) begin
			w = insn_mem[pc[7:0]];
			code = w[63:48];
			jt = w[47:40];
			jf = w[39:32];
			k = w[31:0];
			s = code[3] ? x : k;
			op = code[7:4];
			jumped = 0;
			case (code[2:0])
				CLS_LD: begin
					case (code[7:5])
						MODE_IMM: a = k;
						MODE_ABS: a = sized_fetch(code, {32'b0, k}, plen, a);
						MODE_IND: a = sized_fetch(code, {32'b0, x} + {32'b0, k}, plen, a);
						MODE_MEM: if (k < SCRATCH_DEPTH) a = mem[k[3:0]];
						MODE_LEN: a = plen;
						default: ;
					endcase
				end
				CLS_LDX: begin
					case (code[7:5])
						MODE_IMM: x = k;
						MODE_MEM: if (k < SCRATCH_DEPTH) x = mem[k[3:0]];
						MODE_LEN: x = plen;
						MODE_MSH: begin
							tmp = pkt_fetch({32'b0, k}, 1, plen);
							x = {26'b0, tmp[3:0], 2'b00};
						end
						default: ;
					endcase
				end
				CLS_ST: if (k < SCRATCH_DEPTH) mem[k[3:0]] = a;
				CLS_STX: if (k < SCRATCH_DEPTH) mem[k[3:0]] = x;
				CLS_ALU: begin
					case (op)
						ALU_ADD: a = a + s;
						ALU_SUB: a = a - s;
						ALU_MUL: a = a * s;
						ALU_DIV, ALU_MOD: begin
							if (s == 0) begin
								res.verdict = '0;
								res.end_cause = CAUSE_DIV0;
								return res;
							end
							a = (op == ALU_DIV) ? a / s : a % s;
						end
						ALU_OR: a = a | s;
						ALU_AND: a = a & s;
						ALU_LSH: a = (s < 32) ? a << s : '0;
						ALU_RSH: a = (s < 32) ? a >> s : '0;
						ALU_NEG: a = 32'd0 - a;
						ALU_XOR: a = a ^ s;
						default: ;
					endcase
				end
				CLS_JMP: begin
					if (op == JMP_JA) begin
						pc = pc + {32'b0, k} + 64'd1;
						jumped = 1;
					end else if (op inside {JMP_JEQ, JMP_JGT, JMP_JGE, JMP_JSET}) begin
						case (op)
							JMP_JEQ: cond = (a == s);
							JMP_JGT: cond = (a > s);
							JMP_JGE: cond = (a >= s);
							default: cond = ((a & s) != 0);
						endcase
						pc = pc + {56'b0, cond ? jt : jf} + 64'd1;
						jumped = 1;
					end
				end
				CLS_RET: begin
					res.verdict = (code[4:3] == SIZE_B) ? a : k;
					res.end_cause = CAUSE_RET;
					return res;
				end
				default: begin
					if (code[7:3] == MISC_TAX)
						x = a;
					else if (code[7:3] == MISC_TXA)
						a = x;
				end
			endcase
			if (!jumped)
				pc = pc + 64'd1;
		end
		res.verdict = '0;
		res.end_cause = CAUSE_END;
		return res;
	endfunction

	// Drives one item, waits for its transaction and updates the predictor.
	task automatic send_item(filter_item_t it);
		int g;
		cmd_ch.valid <= 1'b1;
		cmd_ch.operation <= it.operation;
		cmd_ch.slot <= it.slot;
		cmd_ch.insn_code <= it.insn_code;
		cmd_ch.jump_true <= it.jump_true;
		cmd_ch.jump_false <= it.jump_false;
		cmd_ch.immediate <= it.immediate;
		cmd_ch.packet_byte <= it.packet_byte;
		cmd_ch.packet_length <= it.packet_length;
		do
			@(posedge clk);
		while (!(cmd_ch.valid && cmd_ch.ready));
		item_count++;
		case (it.operation)
			OP_WR_INSN: if (it.slot < PROGRAM_DEPTH_DEF)
				insn_mem[it.slot[7:0]] = {it.insn_code, it.jump_true, it.jump_false,
					it.immediate};
			OP_WR_PKT: pkt_mem[it.slot] = it.packet_byte;
			OP_RUN: begin
				verdict_queue.push_back(predict_run(it.packet_length));
				run_count++;
			end
			default: ;
		endcase
		g = gap_len();
		if (g > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic filter_item_t noise_item();
		filter_item_t it;
		it.operation = 2'($urandom_range(0, 3));
		it.slot = 11'($urandom);
		it.insn_code = 16'($urandom);
		it.jump_true = 8'($urandom);
		it.jump_false = 8'($urandom);
		it.immediate = $urandom;
		it.packet_byte = 8'($urandom);
		it.packet_length = 12'($urandom);
		return it;
	endfunction

	task automatic put_insn(int slot, logic [7:0] low, logic [31:0] k,
		logic [7:0] jt = 0, logic [7:0] jf = 0);
		filter_item_t it;
		it = noise_item();
		it.operation = OP_WR_INSN;
		it.slot = 11'(slot);
		it.insn_code = {it.insn_code[15:8], low};
		it.jump_true = jt;
		it.jump_false = jf;
		it.immediate = k;
		send_item(it);
	endtask

	task automatic put_byte(int slot, logic [7:0] b);
		filter_item_t it;
		it = noise_item();
		it.operation = OP_WR_PKT;
		it.slot = 11'(slot);
		it.packet_byte = b;
		send_item(it);
	endtask

	task automatic run_filter(int plen);
		filter_item_t it;
		it = noise_item();
		it.operation = OP_RUN;
		it.packet_length = 12'(plen);
		send_item(it);
	endtask

	// Holds the sender until every run has answered, then lets the engine settle.
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_length(int v);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= 9'(v);
		do
			@(posedge clk);
		while (!(cfg_ch.valid && cfg_ch.ready));
		cfg_ch.valid <= 1'b0;
		prog_len_reg = 9'(v);
	endtask

	// Every program slot and the low packet bytes are written once so that no
	// run reads an unwritten location.
	task automatic test_fill_stores();
		quiet = 1;
		for (int i = 0; i < PROGRAM_DEPTH_DEF; i++)
			put_insn(i, {ALU_ADD, 1'b0, CLS_ALU}, $urandom);
		for (int i = 0; i < PKT_FILL; i++)
			put_byte(i, 8'($urandom));
		quiet = 0;
	endtask

	task automatic test_empty_and_full();
		set_length(0);
		run_filter(0);
		set_length(256);
		run_filter(2048);
		set_length(511);
		run_filter(4095);
	endtask

	task automatic test_divide();
		put_insn(0, {MODE_IMM, SIZE_W, CLS_LD}, 32'd7);
		put_insn(1, {ALU_DIV, 1'b1, CLS_ALU}, 32'd5);
		put_insn(2, {3'b000, SIZE_B, CLS_RET}, 32'd9);
		set_length(3);
		run_filter(10);
		put_insn(1, {ALU_MOD, 1'b0, CLS_ALU}, 32'd0);
		run_filter(10);
		put_insn(1, {ALU_DIV, 1'b0, CLS_ALU}, 32'd3);
		run_filter(10);
	endtask

	task automatic test_shift_and_loads();
		put_insn(0, {MODE_IMM, SIZE_W, CLS_LD}, 32'hffff_ffff);
		put_insn(1, {ALU_LSH, 1'b0, CLS_ALU}, 32'd32);
		run_filter(1);
		put_insn(1, {ALU_RSH, 1'b0, CLS_ALU}, 32'd31);
		run_filter(1);
		put_insn(0, {MODE_ABS, SIZE_W, CLS_LD}, 32'd2045);
		put_insn(1, {ALU_ADD, 1'b0, CLS_ALU}, 32'd0);
		run_filter(2048);
		run_filter(4095);
		put_insn(0, {MODE_IMM, SIZE_W, CLS_LDX}, 32'hffff_ffff);
		put_insn(1, {MODE_IND, SIZE_B, CLS_LD}, 32'd1);
		run_filter(2048);
		put_insn(0, {MODE_MSH, SIZE_B, CLS_LDX}, 32'd3);
		put_insn(1, {MISC_TXA, CLS_MISC}, 32'd0);
		run_filter(64);
		put_insn(0, {MODE_LEN, SIZE_W, CLS_LD}, 32'd0);
		put_insn(1, {JMP_JA, 1'b0, CLS_JMP}, 32'd255);
		run_filter(3000);
	endtask

	function automatic logic [31:0] rand_imm();
		case ($urandom_range(0, 7))
			0, 1: return $urandom_range(0, 17);
			2: return $urandom_range(0, 70);
			3: return $urandom_range(0, 40);
			4: return 32'd0;
			5: return $urandom_range(PKT_FILL - 8, PKT_FILL + 12);
			6: return 32'hffff_fff0 | $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic put_rand_insn(int slot);
		logic [7:0] low;
		logic [2:0] md;
		logic [3:0] op;
		logic [7:0] jt, jf;
		md = 3'($urandom);
		op = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(0, 10));
		jt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		jf = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		case ($urandom_range(0, 9))
			0, 1: low = {($urandom_range(0, 3) == 0) ? md : 3'($urandom_range(0, 4)),
				2'($urandom), CLS_LD};
			2: low = {($urandom_range(0, 3) == 0) ? md : 3'($urandom_range(0, 5)),
				2'($urandom), CLS_LDX};
			3: low = {5'($urandom), CLS_ST};
			4: low = {5'($urandom), CLS_STX};
			5, 6: low = {op, 1'($urandom), CLS_ALU};
			7: low = {($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, 4)),
				1'($urandom), CLS_JMP};
			8: low = {5'($urandom), CLS_RET};
			default: low = {($urandom_range(0, 3) == 0) ? 5'($urandom) :
				(($urandom_range(0, 1) == 0) ? MISC_TAX : MISC_TXA), CLS_MISC};
		endcase
		if (low[2:0] == CLS_JMP && low[7:4] == JMP_JA && $urandom_range(0, 3) != 0)
			put_insn(slot, low, $urandom_range(0, 4), jt, jf);
		else
			put_insn(slot, low, rand_imm(), jt, jf);
	endtask

	task automatic test_random_programs();
		int len, wr, stop_at, plen;
		stop_at = item_count + 1250;
		while (item_count < stop_at) begin
			case ($urandom_range(0, 39))
				0: len = 0;
				1: len = 256;
				2: len = $urandom_range(257, 511);
				3: len = $urandom_range(13, 255);
				default: len = $urandom_range(1, 12);
			endcase
			quiet = ($urandom_range(0, 5) == 0);
			set_length(len);
			wr = (len > 12) ? $urandom_range(0, 6) : len;
			for (int i = 0; i < wr; i++)
				put_rand_insn(i);
			if (wr > 0 && $urandom_range(0, 3) != 0)
				put_insn(wr - 1, {3'($urandom), ($urandom_range(0, 1) == 0) ? SIZE_B : SIZE_W,
					CLS_RET}, rand_imm());
			repeat ($urandom_range(0, 4))
				put_byte($urandom_range(0, 70), 8'($urandom));
			if ($urandom_range(0, 3) == 0)
				put_byte($urandom_range(0, 2047), 8'($urandom));
			if ($urandom_range(0, 7) == 0)
				put_insn($urandom_range(256, 2047), 8'($urandom), $urandom);
			if ($urandom_range(0, 7) == 0) begin
				filter_item_t it;
				it = noise_item();
				it.operation = 2'd3;
				send_item(it);
			end
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 5))
					0: plen = $urandom_range(0, PKT_FILL);
					1: plen = $urandom_range(PKT_FILL - 8, PKT_FILL);
					default: plen = $urandom_range(0, 72);
				endcase
				run_filter(plen);
			end
		end
		quiet = 0;
	endtask

	// Response stalls: mostly short, a few long, with stretches of none.
	int stall_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (!quiet && $urandom_range(0, 3) == 0)
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (verdict_queue.size() == 0) begin
				$display("%0t: unexpected response verdict=%h end_cause=%0d", $realtime,
					rsp_ch.verdict, rsp_ch.end_cause);
				errors++;
			end else begin
				want = verdict_queue.pop_front();
				cause_seen[rsp_ch.end_cause]++;
				if (rsp_ch.verdict !== want.verdict) begin
					$display("%0t: verdict expected %h actual %h", $realtime,
						want.verdict, rsp_ch.verdict);
					errors++;
				end
				if (rsp_ch.end_cause !== want.end_cause) begin
					$display("%0t: end_cause expected %0d actual %0d", $realtime,
						want.end_cause, rsp_ch.end_cause);
					errors++;
				end
			end
		end
	end

	initial begin
		errors = 0;
		item_count = 0;
		run_count = 0;
		quiet = 0;
		prog_len_reg = '0;
		foreach (cause_seen[i])
			cause_seen[i] = 0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.operation = '0;
		cmd_ch.slot = '0;
		cmd_ch.insn_code = '0;
		cmd_ch.jump_true = '0;
		cmd_ch.jump_false = '0;
		cmd_ch.immediate = '0;
		cmd_ch.packet_byte = '0;
		cmd_ch.packet_length = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_stores();
		test_empty_and_full();
		test_divide();
		test_shift_and_loads();
		test_random_programs();

		cmd_ch.valid <= 1'b0;
		while (verdict_queue.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("Sent %0d items including %0d runs; end causes return/div0/end/empty: %0d/%0d/%0d/%0d",
			item_count, run_count, cause_seen[0], cause_seen[1], cause_seen[2], cause_seen[3]);
		if (errors == 0)
			$display("packet_filter_bytecode_engine test passed");
		else
			$display("packet_filter_bytecode_engine test failed");
		$finish;
	end

endmodule
